// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// the enclosing scope provides clk and rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define DFRC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfrc assertion failed");

// next-cycle implication, off while reset is high
`define DFRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfrc assertion failed");

// next-cycle implication that is also checked while reset is high
`define DFRC_ASSERT_ALWAYS_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dfrc assertion failed");

`endif

// ===== rtl/dfrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfrc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned RUN_W   = 17;
  localparam int unsigned SET_W   = 256;
  localparam int unsigned WORD_W  = 64;

  localparam logic [BYTE_W-1:0] CHAR_GT      = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CHAR_NL      = 8'h0A;  // line feed
  localparam logic [BYTE_W-1:0] CHAR_UPPER_N = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_N = 8'h6E;

  localparam logic [SET_W-1:0] DEGEN_SET_RESET =
    (SET_W'(1) << CHAR_UPPER_N) | (SET_W'(1) << CHAR_LOWER_N);
  localparam logic [LIMIT_W-1:0] MAX_DEGEN_RESET = 16'd20;
  localparam logic [LIMIT_W-1:0] MAX_LINE_RESET  = 16'd32768;

  // register indexes on the config channel
  typedef enum logic [2:0] {
    REG_DEGEN_SET_0 = 3'd0,
    REG_DEGEN_SET_1 = 3'd1,
    REG_DEGEN_SET_2 = 3'd2,
    REG_DEGEN_SET_3 = 3'd3,
    REG_MAX_DEGEN   = 3'd4,
    REG_MAX_LINE    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [SET_W-1:0]   degen_set;
    logic [LIMIT_W-1:0] max_degen;
    logic [LIMIT_W-1:0] max_line;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/dfrc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfrc_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [dfrc_pkg::WORD_W-1:0]  cfg_data,
  output dfrc_pkg::cfg_t                    cfg
);

  dfrc_pkg::cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.degen_set <= dfrc_pkg::DEGEN_SET_RESET;
      regs.max_degen <= dfrc_pkg::MAX_DEGEN_RESET;
      regs.max_line  <= dfrc_pkg::MAX_LINE_RESET;
    end else if (cfg_valid) begin
      unique case (dfrc_pkg::reg_index_t'(cfg_index))
        dfrc_pkg::REG_DEGEN_SET_0: regs.degen_set[0*dfrc_pkg::WORD_W +: dfrc_pkg::WORD_W]
                                     <= cfg_data;
        dfrc_pkg::REG_DEGEN_SET_1: regs.degen_set[1*dfrc_pkg::WORD_W +: dfrc_pkg::WORD_W]
                                     <= cfg_data;
        dfrc_pkg::REG_DEGEN_SET_2: regs.degen_set[2*dfrc_pkg::WORD_W +: dfrc_pkg::WORD_W]
                                     <= cfg_data;
        dfrc_pkg::REG_DEGEN_SET_3: regs.degen_set[3*dfrc_pkg::WORD_W +: dfrc_pkg::WORD_W]
                                     <= cfg_data;
        dfrc_pkg::REG_MAX_DEGEN:   regs.max_degen <= cfg_data[dfrc_pkg::LIMIT_W-1:0];
        dfrc_pkg::REG_MAX_LINE:    regs.max_line  <= cfg_data[dfrc_pkg::LIMIT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fasta_degenerate_run_clipper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tdata[7:0] in_byte
// m_*       out  m_tvalid / m_tready       m_tdata[7:0] out_byte, m_tlast last_of_run
// cfg_*     in   cfg_valid / cfg_ready     cfg_index[2:0], cfg_data[63:0]
//
// one input byte per cycle while the result register can take it: input register,
// combinational decode, then a two-entry result register that drains one byte
// per cycle while m_tready is high; a byte that gives two results (line break
// insertion) holds the input side while the second result goes out
// rst is synchronous: state, valid flags and config registers return to defaults
// cfg_ready is always high; writes are meant for idle periods only

module fasta_degenerate_run_clipper (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
  // output stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,    // [7:0] out_byte
  output      logic        m_tlast,    // last_of_run: final result of one input byte
  // config write channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned BW = dfrc_pkg::BYTE_W;
  localparam int unsigned LW = dfrc_pkg::LIMIT_W;
  localparam int unsigned RW = dfrc_pkg::RUN_W;

  dfrc_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  dfrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  logic          in_valid;
  logic [BW-1:0] in_byte;

  // filter state
  logic          in_header, in_header_next;
  logic [RW-1:0] run_count, run_count_next;
  logic [LW-1:0] line_count, line_count_next;

  // result register: up to two bytes, the second always ends the item
  logic [1:0]    out_cnt;
  logic [BW-1:0] out_byte0, out_byte1;

  logic          fire;
  logic [1:0]    res_cnt;
  logic [BW-1:0] res_byte0, res_byte1;

  // room for a new item once the result register empties this cycle
  assign fire     = in_valid && ((out_cnt == 2'd0) || ((out_cnt == 2'd1) && m_tready));
  assign s_tready = !in_valid || fire;

  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = out_byte0;
  assign m_tlast  = (out_cnt == 2'd1);

  // decode of one byte against the current state
  logic          is_degen;
  logic [RW-1:0] run_inc, run_cap, run_sat;
  logic [RW-1:0] line_inc;
  logic          line_full;

  always_comb begin
    is_degen  = cfg.degen_set[in_byte];
    run_inc   = run_count + RW'(1);
    run_cap   = {1'b0, cfg.max_degen} + RW'(1);
    run_sat   = (run_inc < run_cap) ? run_inc : run_cap;
    line_inc  = {1'b0, line_count} + RW'(1);
    line_full = (line_inc >= {1'b0, cfg.max_line});

    in_header_next  = in_header;
    run_count_next  = run_count;
    line_count_next = line_count;
    res_cnt         = 2'd0;
    res_byte0       = in_byte;
    res_byte1       = dfrc_pkg::CHAR_NL;

    priority if (in_header) begin
      // header text is copied through its line break
      res_cnt = 2'd1;
      if (in_byte == dfrc_pkg::CHAR_NL) begin
        in_header_next = 1'b0;
      end
    end else if (in_byte == dfrc_pkg::CHAR_GT) begin
      // close a partly filled sequence line before the header
      in_header_next = 1'b1;
      if (line_count != '0) begin
        res_cnt         = 2'd2;
        res_byte0       = dfrc_pkg::CHAR_NL;
        res_byte1       = in_byte;
        line_count_next = '0;
      end else begin
        res_cnt = 2'd1;
      end
    end else if (is_degen || (in_byte != dfrc_pkg::CHAR_NL)) begin
      // run_sat never exceeds max_degen + 1, so the compare fits
      run_count_next = is_degen ? run_sat : '0;
      if (!is_degen || (run_sat <= {1'b0, cfg.max_degen})) begin
        if (line_full) begin
          res_cnt         = 2'd2;
          line_count_next = '0;
        end else begin
          res_cnt         = 2'd1;
          line_count_next = line_inc[LW-1:0];
        end
      end
    end else begin
      // sequence line break is dropped
      res_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header  <= 1'b0;
      run_count  <= '0;
      line_count <= '0;
    end else if (fire) begin
      in_header  <= in_header_next;
      run_count  <= run_count_next;
      line_count <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (fire) begin
      out_cnt <= res_cnt;
    end else if (m_tvalid && m_tready) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte0 <= res_byte0;
      out_byte1 <= res_byte1;
    end else if (m_tvalid && m_tready) begin
      out_byte0 <= out_byte1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dfrc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // nothing is offered right after reset
  `DFRC_ASSERT_ALWAYS_NEXT(a_idle_after_reset, rst, !m_tvalid)

  // a stalled result holds its value
  `DFRC_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // the first of a pair is followed at once by the closing result
  `DFRC_ASSERT_NEXT(a_pair_closes, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)

  // input is held back only while a result is waiting
  `DFRC_ASSERT_SAME(a_stall_has_cause, !s_tready, m_tvalid)

endmodule

bind fasta_degenerate_run_clipper dfrc_checker u_dfrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_fasta_degenerate_run_clipper.sv =====
`timescale 1ns / 1ps

// expected-text tracker: keeps a private copy of the clipper state and
// settings, turns every accepted request into the bytes it should produce
class degen_clip_scoreboard;

  // settings as last written
  logic [255:0] degen_bits;
  logic [15:0]  max_degen;
  logic [15:0]  max_line;

  // text state
  bit           in_hdr;
  logic [16:0]  run_len;
  logic [16:0]  line_fill;

  // bytes produced by the request being worked out
  logic [7:0]   step_bytes[2];
  int           step_n;

  // outstanding output, oldest first
  logic [7:0]   pending_byte[$];
  bit           pending_last[$];

  int unsigned  errors;
  int unsigned  bytes_in;
  int unsigned  bytes_out;
  int unsigned  headers;
  int unsigned  clipped;
  int unsigned  breaks_added;
  int unsigned  double_steps;

  function new();
    degen_bits = dfrc_pkg::DEGEN_SET_RESET;
    max_degen  = dfrc_pkg::MAX_DEGEN_RESET;
    max_line   = dfrc_pkg::MAX_LINE_RESET;
    in_hdr     = 0;
    run_len    = '0;
    line_fill  = '0;
    errors     = 0;
    bytes_in   = 0;
    bytes_out  = 0;
    headers    = 0;
    clipped    = 0;
    breaks_added = 0;
    double_steps = 0;
  endfunction

  function void load_register(dfrc_pkg::reg_index_t idx, logic [63:0] val);
    case (idx)
      dfrc_pkg::REG_DEGEN_SET_0: degen_bits[63:0]    = val;
      dfrc_pkg::REG_DEGEN_SET_1: degen_bits[127:64]  = val;
      dfrc_pkg::REG_DEGEN_SET_2: degen_bits[191:128] = val;
      dfrc_pkg::REG_DEGEN_SET_3: degen_bits[255:192] = val;
      dfrc_pkg::REG_MAX_DEGEN:   max_degen = val[15:0];
      dfrc_pkg::REG_MAX_LINE:    max_line  = val[15:0];
      default: ;
    endcase
  endfunction

  function bit is_degen(logic [7:0] c);
    return degen_bits[c];
  endfunction

  function int pending();
    return pending_byte.size();
  endfunction

  function void add_byte(logic [7:0] b);
    step_bytes[step_n] = b;
    step_n++;
  endfunction

  // sequence byte out, then a line break once the line is full
  function void put_seq_byte(logic [7:0] c);
    add_byte(c);
    line_fill = line_fill + 17'd1;
    if (line_fill >= {1'b0, max_line}) begin
      add_byte(dfrc_pkg::CHAR_NL);
      line_fill = '0;
      breaks_added++;
    end
  endfunction

  function void clip_and_queue(logic [7:0] c);
    logic [16:0] ceiling;
    ceiling = {1'b0, max_degen} + 17'd1;
    step_n = 0;
    bytes_in++;
    if (in_hdr) begin
      add_byte(c);
      if (c == dfrc_pkg::CHAR_NL) in_hdr = 0;
    end else if (c == dfrc_pkg::CHAR_GT) begin
      // header start closes a partly filled sequence line
      if (line_fill != 0) begin
        add_byte(dfrc_pkg::CHAR_NL);
        line_fill = '0;
        breaks_added++;
      end
      add_byte(c);
      in_hdr = 1;
      headers++;
    end else if (degen_bits[c]) begin
      // saturating run length, also clamps after max_degen was lowered
      if (run_len + 17'd1 < ceiling) run_len = run_len + 17'd1;
      else run_len = ceiling;
      if (run_len <= {1'b0, max_degen}) put_seq_byte(c);
      else clipped++;
    end else if (c != dfrc_pkg::CHAR_NL) begin
      run_len = '0;
      put_seq_byte(c);
    end
    if (step_n == 2) double_steps++;
    for (int i = 0; i < step_n; i++) begin
      pending_byte.push_back(step_bytes[i]);
      pending_last.push_back(i == step_n - 1);
    end
  endfunction

  function void match_output(logic [7:0] b, logic last);
    logic [7:0] want_b;
    bit         want_last;
    bytes_out++;
    if (pending_byte.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected output byte %02h last %0b with nothing pending", b, last);
      return;
    end
    want_b    = pending_byte.pop_front();
    want_last = pending_last.pop_front();
    if (b !== want_b || last !== want_last) begin
      errors++;
      if (errors <= 10)
        $display("output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                 want_b, want_last, b, last);
    end
  endfunction

endclass

module tb_fasta_degenerate_run_clipper;
  import dfrc_pkg::*;

  localparam int DRAIN_CYCLES = 8;     // quiet wait past the pipeline depth
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off under pressure
  localparam int END_GUARD    = 20000; // final wait for stragglers

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic        m_tlast;        // last_of_run
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  degen_clip_scoreboard sb;

  // idle rates in percent, set per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // long hold-off requests, counted by the receiver process
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;

  // fasta text generator state
  bit gen_hdr     = 0;
  int burst_left  = 0;

  fasta_degenerate_run_clipper DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a counted hold-off when one is requested
  always @(posedge clk) begin
    if (holds_done < holds_asked && hold_left == 0) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // both handshakes observed at the same edge; output checked first so an
  // unexpected byte never pairs with a request accepted in the same cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.match_output(m_tdata, m_tlast);
      if (s_tvalid && s_tready) sb.clip_and_queue(s_tdata);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout with %0d output bytes still pending", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // write all six registers back to back, then release the channel
  task automatic configure(input logic [63:0] set0, input logic [63:0] set1,
                           input logic [63:0] set2, input logic [63:0] set3,
                           input logic [15:0] degen_max, input logic [15:0] line_max);
    reg_index_t  idx [6];
    logic [63:0] val [6];
    idx = '{REG_DEGEN_SET_0, REG_DEGEN_SET_1, REG_DEGEN_SET_2, REG_DEGEN_SET_3,
            REG_MAX_DEGEN, REG_MAX_LINE};
    val = '{set0, set1, set2, set3, {48'd0, degen_max}, {48'd0, line_max}};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.load_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // offer one request; tvalid stays high on return so the next byte can follow
  task automatic drive_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drive_text(input string s);
    for (int i = 0; i < s.len(); i++) drive_byte(s[i]);
  endtask

  // idle point: every expected byte out, then a DRAIN_CYCLES wait for dropped bytes
  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_degen();
    logic [7:0] b;
    // favor the usual ambiguity letters when they are in the set
    if ($urandom_range(0, 1) == 0) begin
      b = ($urandom_range(0, 1) == 0) ? CHAR_UPPER_N : CHAR_LOWER_N;
      if (sb.is_degen(b)) return b;
    end
    repeat (8) begin
      b = 8'($urandom_range(0, 255));
      if (sb.is_degen(b)) return b;
    end
    return CHAR_UPPER_N;
  endfunction

  // mostly well-formed fasta: headers, base lines, degenerate bursts
  // that can run past the clip limit, with stray bytes mixed in
  function automatic logic [7:0] next_fasta_byte();
    logic [7:0] bases [4];
    logic [7:0] b;
    int         roll;
    int         cap;
    bases = '{8'h41, 8'h43, 8'h47, 8'h54};
    roll  = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      // line breaks inside a run must not end it
      b = (roll < 8) ? CHAR_NL : pick_degen();
    end else if (gen_hdr) begin
      if (roll < 10)      b = CHAR_NL;
      else if (roll < 18) b = 8'($urandom_range(0, 255));
      else                b = 8'($urandom_range(32, 126));
    end else begin
      if (roll < 3)       b = CHAR_GT;
      else if (roll < 12) b = CHAR_NL;
      else if (roll < 22) begin
        cap = int'(sb.max_degen) + 3;
        if (cap > 40) cap = 40;
        burst_left = $urandom_range(1, cap);
        b = pick_degen();
      end
      else if (roll < 30) b = 8'($urandom_range(0, 255));
      else                b = bases[$urandom_range(0, 3)];
    end
    if (gen_hdr) begin
      if (b == CHAR_NL) gen_hdr = 0;
    end else if (b == CHAR_GT) begin
      gen_hdr = 1;
    end
    return b;
  endfunction

  // one random phase at the given idle rates; optional receiver hold-offs
  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input bit pressure);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (pressure && (i == 0 || i == count / 2)) holds_asked <= holds_asked + 1;
      drive_byte(next_fasta_byte());
    end
    s_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    int mode_send [3];
    int mode_recv [3];
    int guard;
    sb = new();
    mode_send = '{68, 0, 35};
    mode_recv = '{0, 68, 35};

    // reset once, then released
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short lines and a clip limit of two so these paths show up
    // within a few bytes: line wrap with two outputs, run clipping across a
    // dropped line break, header closing a partial line, header copying
    // '>' and line breaks, extreme byte codes in header and sequence
    configure(64'd0, DEGEN_SET_RESET[127:64], 64'd0, 64'd0, 16'd2, 16'd4);
    drive_text("ACNNNN\nnT>h");
    drive_byte(8'h00);
    drive_text(">");
    drive_byte(8'hFF);
    drive_text("\n\n");
    drive_byte(8'h00);
    drive_byte(8'hFF);
    drive_text("nN");
    s_tvalid <= 1'b0;
    wait_drained();

    // directed: line break and '>' in the degenerate set, zero line length
    configure((64'd1 << CHAR_NL) | (64'd1 << CHAR_GT), DEGEN_SET_RESET[127:64],
              64'd0, 64'd0, 16'd2, 16'd0);
    drive_text("\n\n>q\n");
    s_tvalid <= 1'b0;
    wait_drained();

    // random set bits above code 63, no idling at all
    configure(64'd0, DEGEN_SET_RESET[127:64] | ({$urandom, $urandom} & {$urandom, $urandom}),
              {$urandom, $urandom}, {$urandom, $urandom} & {$urandom, $urandom},
              16'd5, 16'd13);
    run_phase(150, 0, 0, 0);

    // every degenerate byte clipped, one byte per line, sender idling
    configure(64'd0, DEGEN_SET_RESET[127:64], {$urandom, $urandom}, 64'd0,
              16'd0, 16'd1);
    run_phase(130, 68, 0, 0);

    // everything degenerate, widest limits, receiver stalling
    configure('1, '1, '1, '1, 16'hFFFF, 16'hFFFF);
    run_phase(100, 0, 68, 0);

    // limits dropped below the run and line built up above
    configure(64'd0, DEGEN_SET_RESET[127:64], 64'd0, '1, 16'd1, 16'd2);
    run_phase(120, 35, 35, 0);

    // sender keeps offering while the receiver holds off, input side stalls
    configure(64'd1 << CHAR_NL, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, 16'd4, 16'd9);
    run_phase(150, 0, 0, 1);

    // random settings under each idle mix
    for (int p = 0; p < 3; p++) begin
      configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, 16'($urandom_range(0, 12)),
                16'($urandom_range(0, 40)));
      run_phase(85, mode_send[p], mode_recv[p], 0);
    end

    // final drain with a bound, then a quiet DRAIN_CYCLES wait for stray output
    guard = 0;
    while (sb.pending() != 0 && guard < END_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected output bytes never arrived", sb.pending());
    end

    $display("run covered %0d input bytes and %0d checked output bytes, %0d headers",
             sb.bytes_in, sb.bytes_out, sb.headers);
    $display("%0d degenerate bytes clipped, %0d line breaks inserted, %0d two-byte steps",
             sb.clipped, sb.breaks_added, sb.double_steps);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
